>>> design/rgb_to_hsv_converter_top_macros.svh
// Assertion helpers for the color converter.
`ifndef RGB_TO_HSV_CONVERTER_TOP_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_TOP_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define RHC_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define RHC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/rhc_pkg.sv
package rhc_pkg;

    // Field widths
    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned RES_W      = 15;
    localparam int unsigned NUM_W      = 23;
    localparam int unsigned DIV_STAGES = RES_W;
    localparam int unsigned LANES      = 2;

    // Lane numbers of the shared divider array
    localparam int unsigned LANE_HUE = 0;
    localparam int unsigned LANE_SAT = 1;

    // Scale constants
    localparam logic [NUM_W-1:0]  HUE_SECTOR = NUM_W'(3840);
    localparam logic [NUM_W-1:0]  PCT_SCALE  = NUM_W'(25600);
    localparam logic [CHAN_W-1:0] CHAN_MAX   = CHAN_W'(255);
    localparam logic [RES_W-1:0]  HUE_FULL   = RES_W'(23040);

    // Value by reciprocal multiply: (max * 25600 + 127) * ceil(2^31 / 255) >> 31
    localparam int unsigned      VAL_W     = 46;
    localparam int unsigned      VAL_SHIFT = 31;
    localparam logic [VAL_W-1:0] VAL_MUL   = 46'd215590528000;
    localparam logic [VAL_W-1:0] VAL_ADD   = 46'd1069531135;

    // Sector offsets in units of one sixth of a turn
    localparam logic [2:0] OFF_RED      = 3'd0;
    localparam logic [2:0] OFF_GREEN    = 3'd2;
    localparam logic [2:0] OFF_BLUE     = 3'd4;
    localparam logic [2:0] OFF_RED_WRAP = 3'd6;

    // Which channel holds the maximum
    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } sector_t;

    // One lane of the restoring divider
    typedef struct packed {
        logic [NUM_W-1:0]  rem;
        logic [CHAN_W-1:0] dvsr;
        logic [RES_W-1:0]  quo;
    } div_lane_t;

endpackage

>>> design/rgb_to_hsv_converter_top.sv
// Channel  | Ports                                   | Direction
// ---------+-----------------------------------------+----------
// pixel    | s_valid s_ready s_red s_green s_blue    | in
// hsv      | m_valid m_ready m_hue m_saturation      | out
//          | m_brightness                            |
//
// One pixel enters per cycle while the output is not stalled; the stages are
// min/max, numerators, 15 restoring divider steps at one quotient bit each, output register.
// Two divider lanes run side by side for hue and saturation; value comes
// from a reciprocal multiply of the max in the output stage.
// aresetn is synchronous and clears only the valid bits.
// A stalled output beat freezes the whole pipeline; nothing is dropped.

`include "rgb_to_hsv_converter_top_macros.svh"

module rgb_to_hsv_converter_top
    import rhc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CHAN_W-1:0] s_red,
    input  logic [CHAN_W-1:0] s_green,
    input  logic [CHAN_W-1:0] s_blue,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [RES_W-1:0]  m_hue,
    output logic [RES_W-1:0]  m_saturation,
    output logic [RES_W-1:0]  m_brightness
);

    logic advance;

    // Stage A: extremes and sector
    logic              vld_a_reg;
    logic [CHAN_W-1:0] red_a_reg, green_a_reg, blue_a_reg;
    logic [CHAN_W-1:0] max_a_reg, delta_a_reg;
    sector_t           sect_a_reg;

    logic [CHAN_W-1:0] max_a_next, min_a_next;
    sector_t           sect_a_next;

    // Stage B and divider steps
    div_lane_t         lane_reg  [DIV_STAGES+1][LANES];
    div_lane_t         lane_next [DIV_STAGES+1][LANES];
    logic [DIV_STAGES:0] vld_reg;
    logic [DIV_STAGES:0] grey_reg;
    logic [DIV_STAGES:0] black_reg;

    // Output register
    logic             m_valid_reg;
    logic [RES_W-1:0] m_hue_reg, m_sat_reg, m_val_reg;
    logic [RES_W-1:0] m_hue_next;
    logic [RES_W-1:0] m_val_next;
    logic [VAL_W-1:0] val_prod;

    // Advance every stage whenever the output slot is free or being drained
    assign advance = m_ready || !m_valid_reg;
    assign s_ready = advance;

    // Find max, min and the sector of the max channel
    always_comb begin
        max_a_next = s_red;
        min_a_next = s_red;
        if (s_green > max_a_next) max_a_next = s_green;
        if (s_blue > max_a_next)  max_a_next = s_blue;
        if (s_green < min_a_next) min_a_next = s_green;
        if (s_blue < min_a_next)  min_a_next = s_blue;
        priority if (s_red >= s_green && s_red >= s_blue) begin
            sect_a_next = SECT_RED;
        end else if (s_green >= s_blue) begin
            sect_a_next = SECT_GREEN;
        end else begin
            sect_a_next = SECT_BLUE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_a_reg <= 1'b0;
        end else if (advance) begin
            vld_a_reg <= s_valid;
        end
        if (advance) begin
            red_a_reg   <= s_red;
            green_a_reg <= s_green;
            blue_a_reg  <= s_blue;
            max_a_reg   <= max_a_next;
            delta_a_reg <= max_a_next - min_a_next;
            sect_a_reg  <= sect_a_next;
        end
    end

    // Stage B: build rounded numerators for the two divisions
    logic [8:0]        diff_b;
    logic [2:0]        off_b;
    logic [10:0]       off_d_b;
    logic [10:0]       turns_b;
    logic [11:0]       turns_wide_b;

    always_comb begin
        unique case (sect_a_reg)
            SECT_RED: begin
                diff_b = {1'b0, green_a_reg} - {1'b0, blue_a_reg};
                off_b  = (green_a_reg >= blue_a_reg) ? OFF_RED : OFF_RED_WRAP;
            end
            SECT_GREEN: begin
                diff_b = {1'b0, blue_a_reg} - {1'b0, red_a_reg};
                off_b  = OFF_GREEN;
            end
            SECT_BLUE: begin
                diff_b = {1'b0, red_a_reg} - {1'b0, green_a_reg};
                off_b  = OFF_BLUE;
            end
            default: begin
                diff_b = '0;
                off_b  = OFF_RED;
            end
        endcase
        off_d_b      = 11'(off_b) * 11'(delta_a_reg);
        // Sum is never negative, so the low bits hold it exactly
        turns_wide_b = {1'b0, off_d_b} + {{3{diff_b[8]}}, diff_b};
        turns_b      = turns_wide_b[10:0];

        lane_next[0][LANE_HUE].rem  = NUM_W'(turns_b) * HUE_SECTOR
                                    + NUM_W'(delta_a_reg >> 1);
        lane_next[0][LANE_HUE].dvsr = delta_a_reg;
        lane_next[0][LANE_HUE].quo  = '0;

        lane_next[0][LANE_SAT].rem  = NUM_W'(delta_a_reg) * PCT_SCALE
                                    + NUM_W'(max_a_reg >> 1);
        lane_next[0][LANE_SAT].dvsr = max_a_reg;
        lane_next[0][LANE_SAT].quo  = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (advance) begin
            vld_reg[0] <= vld_a_reg;
        end
        if (advance) begin
            lane_reg[0] <= lane_next[0];
            grey_reg[0]  <= (delta_a_reg == '0);
            black_reg[0] <= (max_a_reg == '0);
        end
    end

    // Divider steps: one quotient bit per stage, most significant first
    for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_step
        localparam int unsigned BIT = DIV_STAGES - k;

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [NUM_W:0] trial;

            always_comb begin
                trial = ({{(NUM_W+1-CHAN_W){1'b0}}, lane_reg[k-1][l].dvsr}) << BIT;
                lane_next[k][l] = lane_reg[k-1][l];
                if ({1'b0, lane_reg[k-1][l].rem} >= trial) begin
                    lane_next[k][l].rem      = lane_reg[k-1][l].rem - trial[NUM_W-1:0];
                    lane_next[k][l].quo[BIT] = 1'b1;
                end
            end

            always_ff @(posedge aclk) begin
                if (advance) begin
                    lane_reg[k][l] <= lane_next[k][l];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (advance) begin
                vld_reg[k] <= vld_reg[k-1];
            end
            if (advance) begin
                grey_reg[k]  <= grey_reg[k-1];
                black_reg[k] <= black_reg[k-1];
            end
        end
    end

    // Output: drop hue for grey, wrap a full turn to zero, zero black saturation
    always_comb begin
        priority if (grey_reg[DIV_STAGES]) begin
            m_hue_next = '0;
        end else if (lane_reg[DIV_STAGES][LANE_HUE].quo >= HUE_FULL) begin
            m_hue_next = '0;
        end else begin
            m_hue_next = lane_reg[DIV_STAGES][LANE_HUE].quo;
        end
        // The saturation lane carries the max down as its divisor
        val_prod   = VAL_W'(lane_reg[DIV_STAGES][LANE_SAT].dvsr) * VAL_MUL + VAL_ADD;
        m_val_next = val_prod[VAL_SHIFT +: RES_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= vld_reg[DIV_STAGES];
        end
        if (advance) begin
            m_hue_reg <= m_hue_next;
            m_sat_reg <= black_reg[DIV_STAGES] ? '0 : lane_reg[DIV_STAGES][LANE_SAT].quo;
            m_val_reg <= m_val_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_hue        = m_hue_reg;
    assign m_saturation = m_sat_reg;
    assign m_brightness = m_val_reg;

    // Checks on the result beat
    `RHC_ASSERT_SAME(a_hue_range, aclk, aresetn, m_valid, m_hue < HUE_FULL, "hue out of range")
    `RHC_ASSERT_SAME(a_pct_range, aclk, aresetn, m_valid,
        m_saturation <= RES_W'(25600) && m_brightness <= RES_W'(25600), "percent out of range")
    `RHC_ASSERT_SAME(a_grey_hue, aclk, aresetn, m_valid && m_saturation == '0,
        m_hue == '0, "grey pixel with nonzero hue")
    `RHC_ASSERT_SAME(a_black_sat, aclk, aresetn, m_valid && m_brightness == '0,
        m_saturation == '0, "black pixel with nonzero saturation")
    `RHC_ASSERT_NEXT(a_drain, aclk, aresetn, vld_reg[DIV_STAGES] && advance,
        m_valid, "finished beat not presented")

endmodule
